@@ src/lpr_pkg.sv @@
// lpr_pkg: shared types, register indexes and defaults for the line pixel rasterizer
// no dependencies; imported by every module of the block except lpr_fifo
package lpr_pkg;

	localparam int CMD_DEPTH_DEF = 4;
	localparam int RES_DEPTH_DEF = 4;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_GRAPHICS_BASE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_ROW = 8'd1;

	localparam logic [15:0] GRAPHICS_BASE_RST = 16'd0;
	localparam logic [7:0]  BYTES_PER_ROW_RST = 8'd30;

	localparam logic REQ_BEGIN   = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] col_a;
		logic [7:0] row_a;
		logic [7:0] col_b;
		logic [7:0] row_b;
		logic       draw_mode;
	} lpr_req_t;

	typedef struct packed {
		logic        pixel_valid;
		logic [15:0] byte_address;
		logic [2:0]  bit_index;
		logic        pixel_set;
		logic [7:0]  pixel_row;
		logic [7:0]  pixel_col;
		logic        last_pixel;
	} lpr_rsp_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic       is_begin;
		logic       step_rows;
		logic [7:0] step_lo;
		logic [7:0] step_hi;
		logic [7:0] other_start;
		logic       other_dir;
		logic [7:0] span;
		logic [7:0] other_delta;
		logic       mode;
	} lpr_cmd_t;

	// pixel leaving the stepper, before address generation
	typedef struct packed {
		logic       valid;
		logic [7:0] row;
		logic [7:0] col;
		logic       set;
		logic       last;
	} lpr_pix_t;

endpackage

@@ src/line_pixel_rasterizer_top.sv @@
// line_pixel_rasterizer_top: one request beat in, one pixel beat out
// path: request -> command queue -> stepper pixel register -> result queue
// throughput: one beat per cycle from the stepper, while the result queue has room
// reset: arst_n clears both queues and the line state; base reads 0, stride reads 30
// depends on lpr_pkg, lpr_fifo, lpr_front, lpr_back
module line_pixel_rasterizer_top #(
	parameter int CMD_DEPTH = lpr_pkg::CMD_DEPTH_DEF,
	parameter int RES_DEPTH = lpr_pkg::RES_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  lpr_pkg::lpr_req_t                  req,
	output logic                               empty,
	input  logic                               pop,
	output lpr_pkg::lpr_rsp_t                  result,
	input  logic                               cfg_we,
	input  logic [lpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import lpr_pkg::*;

	localparam int CMD_CNT_W = $clog2(CMD_DEPTH+1);
	localparam int RES_CNT_W = $clog2(RES_DEPTH+1);

	logic [15:0] graphics_base_q;
	logic [7:0]  bytes_per_row_q;

	lpr_cmd_t             cmd_in;
	lpr_cmd_t             cmd_head;
	logic                 cmd_empty;
	logic                 cmd_pop;
	logic [CMD_CNT_W-1:0] cmd_count;
	logic                 in_beat;

	lpr_rsp_t             res_data;
	logic                 res_push;
	logic [RES_CNT_W-1:0] res_count;
	logic                 res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			graphics_base_q <= GRAPHICS_BASE_RST;
			bytes_per_row_q <= BYTES_PER_ROW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRAPHICS_BASE: graphics_base_q <= cfg_data[15:0];
				REG_BYTES_PER_ROW: bytes_per_row_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign in_beat = push && !full;

	lpr_front u_front (
		.req (req),
		.cmd (cmd_in)
	);

	lpr_fifo #(
		.DEPTH (CMD_DEPTH),
		.T     (lpr_cmd_t)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_beat),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty),
		.full    (full),
		.count   (cmd_count)
	);

	lpr_back #(
		.RES_DEPTH (RES_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd_head),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.res_count     (res_count),
		.res_push      (res_push),
		.res           (res_data),
		.graphics_base (graphics_base_q),
		.bytes_per_row (bytes_per_row_q)
	);

	lpr_fifo #(
		.DEPTH (RES_DEPTH),
		.T     (lpr_rsp_t)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.rd_en   (pop && !empty),
		.rd_data (result),
		.empty   (empty),
		.full    (res_full),
		.count   (res_count)
	);

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!res_full || (pop && !empty)))
		else $error("result queue overflow");

	a_cmd_count_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (cmd_count == CMD_CNT_W'(CMD_DEPTH)))
		else $error("command queue count disagrees with full");

	a_idle_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd_empty && !res_push && (res_count == '0)) |=> res_push)
		else $error("stepper stalled with room in result queue");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.pixel_valid) |-> ((result.byte_address == '0) && !result.last_pixel))
		else $error("invalid result beat carries nonzero fields");

endmodule

@@ src/lpr_fifo.sv @@
// lpr_fifo: small synchronous queue with occupancy count
// depends on nothing; depth must be a power of two
module lpr_fifo #(
	parameter int DEPTH = 4,
	parameter type T = logic
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  T                           wr_data,
	input  logic                       rd_en,
	output T                           rd_data,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH+1);

	T                 mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ src/lpr_front.sv @@
// lpr_front: combinational; turns each request beat into a command, classifying begin items into stepping commands
// depends on lpr_pkg
module lpr_front (
	input  lpr_pkg::lpr_req_t req,
	output lpr_pkg::lpr_cmd_t cmd
);

	import lpr_pkg::*;

	logic [7:0] rspan;
	logic [7:0] cspan;
	logic       rows;
	logic       a_low;
	logic [7:0] o_end;

	always_comb begin
		rspan = (req.row_a > req.row_b) ? (req.row_a - req.row_b) : (req.row_b - req.row_a);
		cspan = (req.col_a > req.col_b) ? (req.col_a - req.col_b) : (req.col_b - req.col_a);
		rows  = (cspan <= rspan);

		cmd.is_begin = (req.req_type == REQ_BEGIN);
		cmd.step_rows = rows;
		cmd.mode = req.draw_mode;
		if (rows) begin
			a_low           = (req.row_a <= req.row_b);
			cmd.step_lo     = a_low ? req.row_a : req.row_b;
			cmd.step_hi     = a_low ? req.row_b : req.row_a;
			cmd.other_start = a_low ? req.col_a : req.col_b;
			o_end           = a_low ? req.col_b : req.col_a;
			cmd.span        = rspan;
			cmd.other_delta = cspan;
		end else begin
			a_low           = (req.col_a <= req.col_b);
			cmd.step_lo     = a_low ? req.col_a : req.col_b;
			cmd.step_hi     = a_low ? req.col_b : req.col_a;
			cmd.other_start = a_low ? req.row_a : req.row_b;
			o_end           = a_low ? req.row_b : req.row_a;
			cmd.span        = cspan;
			cmd.other_delta = rspan;
		end
		cmd.other_dir = (o_end < cmd.other_start);
	end

endmodule

@@ src/lpr_back.sv @@
// lpr_back: line stepper with error accumulator and byte address generation
// depends on lpr_pkg; issues only when the result queue has room
module lpr_back #(
	parameter int RES_DEPTH = lpr_pkg::RES_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lpr_pkg::lpr_cmd_t              cmd,
	input  logic                           cmd_empty,
	output logic                           cmd_pop,
	input  logic [$clog2(RES_DEPTH+1)-1:0] res_count,
	output logic                           res_push,
	output lpr_pkg::lpr_rsp_t              res,
	input  logic [15:0]                    graphics_base,
	input  logic [7:0]                     bytes_per_row
);

	import lpr_pkg::*;

	localparam int CNT_W = $clog2(RES_DEPTH+1);

	logic       active_q;
	logic       step_rows_q;
	logic [7:0] step_pos_q;
	logic [7:0] step_end_q;
	logic [7:0] other_pos_q;
	logic       other_dir_q;
	logic [7:0] span_q;
	logic [7:0] delta_q;
	logic [7:0] err_q;
	logic       mode_q;

	logic       active_n;
	logic       step_rows_n;
	logic [7:0] step_pos_n;
	logic [7:0] step_end_n;
	logic [7:0] other_pos_n;
	logic       other_dir_n;
	logic [7:0] span_n;
	logic [7:0] delta_n;
	logic [7:0] err_n;
	logic       mode_n;

	logic [8:0] err_sum;
	logic [CNT_W:0] occupancy;
	lpr_pix_t   pix;

	logic       v_s1;
	lpr_pix_t   pix_s1;

	logic [15:0] row_offset;

	assign occupancy = {1'b0, res_count} + (CNT_W+1)'(v_s1);
	assign cmd_pop   = !cmd_empty && (occupancy < (CNT_W+1)'(RES_DEPTH));

	always_comb begin
		active_n    = active_q;
		step_rows_n = step_rows_q;
		step_pos_n  = step_pos_q;
		step_end_n  = step_end_q;
		other_pos_n = other_pos_q;
		other_dir_n = other_dir_q;
		span_n      = span_q;
		delta_n     = delta_q;
		err_n       = err_q;
		mode_n      = mode_q;
		err_sum     = {1'b0, err_q} + {1'b0, delta_q};
		pix         = '0;

		if (cmd.is_begin) begin
			step_rows_n = cmd.step_rows;
			step_pos_n  = cmd.step_lo;
			step_end_n  = cmd.step_hi;
			other_pos_n = cmd.other_start;
			other_dir_n = cmd.other_dir;
			span_n      = cmd.span;
			delta_n     = cmd.other_delta;
			err_n       = '0;
			mode_n      = cmd.mode;
			active_n    = (cmd.span != '0);
			pix.valid   = 1'b1;
			pix.last    = (cmd.span == '0);
		end else if (active_q) begin
			step_pos_n = step_pos_q + 8'd1;
			if (!other_dir_q) begin
				if (err_sum >= {1'b0, span_q}) begin
					err_n       = 8'(err_sum - {1'b0, span_q});
					other_pos_n = other_pos_q + 8'd1;
				end else begin
					err_n = err_sum[7:0];
				end
			end else begin
				if (err_q < delta_q) begin
					err_n       = err_q + span_q - delta_q;
					other_pos_n = other_pos_q - 8'd1;
				end else begin
					err_n = err_q - delta_q;
				end
			end
			pix.valid = 1'b1;
			pix.last  = (step_pos_n == step_end_q);
			active_n  = !pix.last;
		end

		if (pix.valid) begin
			pix.row = step_rows_n ? step_pos_n : other_pos_n;
			pix.col = step_rows_n ? other_pos_n : step_pos_n;
			pix.set = mode_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			step_rows_q <= 1'b0;
			step_pos_q  <= '0;
			step_end_q  <= '0;
			other_pos_q <= '0;
			other_dir_q <= 1'b0;
			span_q      <= '0;
			delta_q     <= '0;
			err_q       <= '0;
			mode_q      <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= cmd_pop;
			if (cmd_pop) begin
				active_q    <= active_n;
				step_rows_q <= step_rows_n;
				step_pos_q  <= step_pos_n;
				step_end_q  <= step_end_n;
				other_pos_q <= other_pos_n;
				other_dir_q <= other_dir_n;
				span_q      <= span_n;
				delta_q     <= delta_n;
				err_q       <= err_n;
				mode_q      <= mode_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			pix_s1 <= pix;
		end
	end

	// address: row * stride + col / 8 + base, wrapping at 16 bits
	assign row_offset = {8'd0, pix_s1.row} * {8'd0, bytes_per_row};
	assign res_push   = v_s1;

	always_comb begin
		res = '0;
		if (pix_s1.valid) begin
			res.pixel_valid  = 1'b1;
			res.byte_address = row_offset + {11'd0, pix_s1.col[7:3]} + graphics_base;
			res.bit_index    = ~pix_s1.col[2:0];
			res.pixel_set    = pix_s1.set;
			res.pixel_row    = pix_s1.row;
			res.pixel_col    = pix_s1.col;
			res.last_pixel   = pix_s1.last;
		end
	end

endmodule
